>>> rtl/core/sss_pkg.sv
// sss_pkg: shared types, constants and the segment table for the
// seven-segment scan serializer. No dependencies.
package sss_pkg;

  // number of digits in the scan rotation
  localparam int DIGIT_COUNT = 4;
  // digits held in the store, whether scanned or not
  localparam int STORE_DEPTH = 4;
  // bits in one shifted word
  localparam int WORD_BITS   = 16;
  // entries in the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // request function codes
  localparam logic FUNC_STORE = 1'b0;
  localparam logic FUNC_TICK  = 1'b1;

  // glyph code that shows blank
  localparam logic [4:0] BLANK_CODE = 5'd16;
  // digit select for digit 0, shifted left by the scan position
  localparam logic [7:0] SELECT_BASE = 8'h10;

  typedef logic [WORD_BITS-1:0] word_t;

  typedef struct packed {
    logic       func;
    logic [1:0] digit_index;
    logic [4:0] digit_value;
  } cmd_t;

  typedef struct packed {
    logic serial_bit;
    logic latch_pulse;
  } shift_t;

  // active-low segment pattern, blank for sixteen and above
  function automatic logic [7:0] seg_lookup(input logic [4:0] code);
    logic [7:0] pattern;
    case (code)
      5'd0:    pattern = 8'h03;
      5'd1:    pattern = 8'h9F;
      5'd2:    pattern = 8'h25;
      5'd3:    pattern = 8'h0D;
      5'd4:    pattern = 8'h99;
      5'd5:    pattern = 8'h49;
      5'd6:    pattern = 8'h41;
      5'd7:    pattern = 8'h1F;
      5'd8:    pattern = 8'h01;
      5'd9:    pattern = 8'h09;
      5'd10:   pattern = 8'h11;
      5'd11:   pattern = 8'hC1;
      5'd12:   pattern = 8'hE5;
      5'd13:   pattern = 8'h85;
      5'd14:   pattern = 8'h61;
      5'd15:   pattern = 8'h71;
      default: pattern = 8'hFF;
    endcase
    return pattern;
  endfunction

endpackage

>>> rtl/core/sss_front.sv
// sss_front: takes requests, holds the digit store and scan position,
// and forms the word for each tick. Depends on sss_pkg.
module sss_front #(
  parameter int DIGIT_COUNT = sss_pkg::DIGIT_COUNT
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cmd_valid,
  output logic            cmd_ready,
  input  sss_pkg::cmd_t   cmd,
  input  logic            q_full,
  output logic            q_push,
  output sss_pkg::word_t  q_word
);

  logic [4:0] digit_store [sss_pkg::STORE_DEPTH];
  logic [1:0] scan_position;
  logic [1:0] scan_position_next;
  logic [1:0] pos;
  logic [2:0] pos_inc;
  logic [4:0] code;
  logic       accept;

  // stores never wait; a tick waits for queue room
  assign cmd_ready = !q_full || (cmd.func == sss_pkg::FUNC_STORE);
  assign accept    = cmd_valid && cmd_ready;
  assign q_push    = accept && (cmd.func == sss_pkg::FUNC_TICK);

  // current digit, out-of-range positions fold to digit 0
  always_comb begin
    if ({1'b0, scan_position} >= 3'(DIGIT_COUNT)) begin
      pos = 2'd0;
    end else begin
      pos = scan_position;
    end
    pos_inc = {1'b0, pos} + 3'd1;
    if (pos_inc >= 3'(DIGIT_COUNT)) begin
      scan_position_next = 2'd0;
    end else begin
      scan_position_next = pos_inc[1:0];
    end
  end

  // glyph lookup and word assembly
  always_comb begin
    code = digit_store[pos];
    if (code > sss_pkg::BLANK_CODE) begin
      code = sss_pkg::BLANK_CODE;
    end
    q_word = {sss_pkg::SELECT_BASE << pos, sss_pkg::seg_lookup(code)};
  end

  // digit store and scan rotation
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_position <= 2'd0;
      for (int i = 0; i < sss_pkg::STORE_DEPTH; i++) begin
        digit_store[i] <= 5'd0;
      end
    end else if (accept) begin
      if (cmd.func == sss_pkg::FUNC_STORE) begin
        digit_store[cmd.digit_index] <= cmd.digit_value;
      end else begin
        scan_position <= scan_position_next;
      end
    end
  end

endmodule

>>> rtl/core/sss_queue.sv
// sss_queue: short word queue between front and back.
// Depends on sss_pkg.
module sss_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  sss_pkg::word_t  push_word,
  output logic            full,
  input  logic            pop,
  output logic            not_empty,
  output sss_pkg::word_t  pop_word
);

  localparam int PTR_W = (sss_pkg::QUEUE_DEPTH > 1) ? $clog2(sss_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(sss_pkg::QUEUE_DEPTH + 1);

  sss_pkg::word_t entries [sss_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == CNT_W'(sss_pkg::QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign pop_word  = entries[rd_ptr];

  // pointer step with wrap
  function automatic logic [PTR_W-1:0] ptr_step(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(sss_pkg::QUEUE_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + PTR_W'(1);
    end
    return r;
  endfunction

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_word;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_step(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_step(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  a_no_overflow : assert property (@(posedge clk) disable iff (rst)
    full |-> !push || pop)
    else $error("queue written while full");

  a_no_underflow : assert property (@(posedge clk) disable iff (rst)
    pop |-> not_empty)
    else $error("queue read while empty");

  a_count_up : assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + CNT_W'(1))
    else $error("queue count did not follow a lone write");

endmodule

>>> rtl/core/sss_back.sv
// sss_back: shifts each queued word out lsb first, then a latch result.
// Depends on sss_pkg.
module sss_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  input  sss_pkg::word_t  q_word,
  output logic            q_pop,
  output logic            shift_valid,
  input  logic            shift_ready,
  output sss_pkg::shift_t shift
);

  localparam int CNT_W = $clog2(sss_pkg::WORD_BITS + 1);

  logic             busy;
  sss_pkg::word_t   word;
  logic [CNT_W-1:0] cnt;
  logic             last;
  logic             accept;

  assign last        = (cnt == CNT_W'(sss_pkg::WORD_BITS));
  assign accept      = shift_valid && shift_ready;
  assign shift_valid = busy;
  assign q_pop       = q_valid && (!busy || (accept && last));

  // data results carry word lsb; the latch result carries zero
  always_comb begin
    shift.serial_bit  = last ? 1'b0 : word[0];
    shift.latch_pulse = last;
  end

  // shift register and bit counter
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (q_pop) begin
      busy <= 1'b1;
      word <= q_word;
      cnt  <= '0;
    end else if (accept) begin
      if (last) begin
        busy <= 1'b0;
      end else begin
        word <= word >> 1;
        cnt  <= cnt + CNT_W'(1);
      end
    end
  end

  a_stall_holds : assert property (@(posedge clk) disable iff (rst)
    busy && !shift_ready |=> busy && $stable(cnt) && $stable(word))
    else $error("shift state moved during stall");

  a_latch_ends_run : assert property (@(posedge clk) disable iff (rst)
    accept && last |=> !busy || cnt == '0)
    else $error("run did not restart after latch");

  a_load_only_idle : assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !busy || last)
    else $error("word loaded in the middle of a run");

endmodule

>>> rtl/core/seven_segment_scan_serializer_top.sv
// seven_segment_scan_serializer_top: multiplexed seven-segment serial driver.
// Depends on sss_pkg, sss_front, sss_queue and sss_back.
//
// Request channel (cmd_valid/cmd_ready/cmd): a store request writes one
// digit value; a tick request shows the digit at the scan position and
// steps the scan on through the digits in rotation, starting at digit 0.
// Result channel (shift_valid/shift_ready/shift): each tick gives sixteen
// data results, the segment/select word lsb first, then one latch result
// with latch_pulse high and serial_bit low.
// Stores are taken one a cycle and give no results. A tick waits only for
// room in the two-entry queue, so up to two ticks are taken while a run
// is still shifting. On an idle block a tick's word is written into the
// queue, then loaded into the back's word register, and the first result
// is offered from there. The back shifts that register one bit for each
// accepted result and loads the next queued word as the latch is accepted.
// Reset clears the digit store to zero, the scan position to digit 0 and
// empties the queue. A stalled receiver holds the current result; the
// front keeps taking stores and fills the queue with ticks.
module seven_segment_scan_serializer_top #(
  parameter int DIGIT_COUNT = sss_pkg::DIGIT_COUNT
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cmd_valid,
  output logic            cmd_ready,
  input  sss_pkg::cmd_t   cmd,
  output logic            shift_valid,
  input  logic            shift_ready,
  output sss_pkg::shift_t shift
);

  logic           q_full;
  logic           q_push;
  logic           q_pop;
  logic           q_not_empty;
  sss_pkg::word_t q_push_word;
  sss_pkg::word_t q_pop_word;

  // request decode, digit store and word assembly
  sss_front #(
    .DIGIT_COUNT (DIGIT_COUNT)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_word    (q_push_word)
  );

  // word queue
  sss_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_word (q_push_word),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_word  (q_pop_word)
  );

  // serial shifter
  sss_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_not_empty),
    .q_word      (q_pop_word),
    .q_pop       (q_pop),
    .shift_valid (shift_valid),
    .shift_ready (shift_ready),
    .shift       (shift)
  );

endmodule
